@@ hdl/bpr_pkg.sv @@
// ============================================================================
// Bad page run table package
// Shared item type, command codes and queue constants.
// ============================================================================
package bpr_pkg;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_COUNT  = 2'd1,
        CMD_GET    = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        K_NOP,
        K_INSERT,
        K_COUNT,
        K_GET
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  block;
        logic [6:0]  page;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

@@ hdl/bpr_ram.sv @@
// ============================================================================
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ============================================================================
module bpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bpr_queue.sv @@
// ============================================================================
// Bad page run table command queue
// Short FIFO between the command front end and the execution engine.
// ============================================================================
module bpr_queue
    import bpr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_item     i_item,
    input  logic      i_pop,
    output t_item     o_item,
    output t_q_status o_status
);

    localparam int PTRW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTRW-1:0]  r_wp;
    logic [PTRW-1:0]  r_rp;
    logic [CNTW-1:0]  r_cnt;
    logic             s_push;
    logic             s_pop;

    assign s_push = i_push && (r_cnt != CNTW'(QUEUE_DEPTH));
    assign s_pop  = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wp] <= i_item;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_push) begin
                r_wp <= (r_wp == PTRW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PTRW'(1);
            end
            if (s_pop) begin
                r_rp <= (r_rp == PTRW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PTRW'(1);
            end
            if (s_push && !s_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (s_pop && !s_push) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

    assign o_item         = r_mem[r_rp];
    assign o_status.full  = (r_cnt == CNTW'(QUEUE_DEPTH));
    assign o_status.empty = (r_cnt == '0);

endmodule

@@ hdl/bpr_front.sv @@
// ============================================================================
// Bad page run table front end
// Accepts commands, checks ranges and classifies them into queue items.
// ============================================================================
module bpr_front
    import bpr_pkg::*;
#(
    parameter int NUM_BLOCKS      = 256,
    parameter int PAGES_PER_BLOCK = 128
) (
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_block,
    input  logic [6:0] i_page,
    input  logic       i_ready,
    input  t_q_status  i_q_status,
    output logic       o_push,
    output t_item      o_item
);

    logic s_blk_ok;
    logic s_pg_ok;

    assign s_blk_ok = 32'(i_block) < NUM_BLOCKS;
    assign s_pg_ok  = 32'(i_page) < PAGES_PER_BLOCK;

    always_comb begin
        o_item.block = i_block;
        o_item.page  = i_page;
        o_item.kind  = K_NOP;
        unique case (t_cmd'(i_cmd))
            CMD_INSERT: o_item.kind = (s_blk_ok && s_pg_ok) ? K_INSERT : K_NOP;
            CMD_COUNT:  o_item.kind = s_blk_ok ? K_COUNT : K_NOP;
            CMD_GET:    o_item.kind = (s_blk_ok && s_pg_ok) ? K_GET : K_NOP;
            default:    o_item.kind = K_NOP;
        endcase
    end

    assign busy   = !i_ready || i_q_status.full;
    assign o_push = start && !busy;

endmodule

@@ hdl/bpr_back.sv @@
// ============================================================================
// Bad page run table execution engine
// Clears the tables after reset and carries out queued commands.
// ============================================================================
module bpr_back
    import bpr_pkg::*;
#(
    parameter int NUM_BLOCKS      = 256,
    parameter int PAGES_PER_BLOCK = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_q_status  i_q_status,
    input  t_item      i_item,
    output logic       o_pop,
    output logic       o_ready,
    output logic       o_strobe,
    output logic [7:0] o_value
);

    localparam int DEPTH = NUM_BLOCKS * PAGES_PER_BLOCK;
    localparam int AW    = $clog2(DEPTH);
    localparam int BW    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int PW    = $clog2(PAGES_PER_BLOCK);
    localparam int LW    = $clog2(PAGES_PER_BLOCK + 1);
    localparam int EW    = PW + 2;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ADDR, S_DISPATCH, S_GET, S_CNT, S_CHK, S_SCAN,
        S_NXT, S_MRG, S_WR, S_CLR_NXT, S_BT_RD, S_BT_WR
    } t_state;

    t_state          r_state;
    logic [AW-1:0]   r_clr;
    t_item           r_item;
    logic [AW-1:0]   r_pg_addr;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_start_addr;
    logic [AW-1:0]   r_nxt_addr;
    logic [BW-1:0]   r_bt_addr;
    logic [PW-1:0]   r_pg;
    logic [PW-1:0]   r_p;
    logic [PW-1:0]   r_start;
    logic [LW-1:0]   r_len;
    logic            r_merge;
    logic            r_strobe;
    logic [7:0]      r_value;

    logic [AW-1:0]   run_addr;
    logic            run_we;
    logic [LW-1:0]   run_wdata;
    logic [LW-1:0]   run_q;
    logic [BW-1:0]   bt_addr;
    logic            bt_we;
    logic [LW-1:0]   bt_wdata;
    logic [LW-1:0]   bt_q;
    logic [EW-1:0]   s_end;
    logic [EW-1:0]   s_next;

    assign o_ready  = (r_state != S_CLEAR);
    assign o_pop    = (r_state == S_IDLE) && !i_q_status.empty;
    assign o_strobe = r_strobe;
    assign o_value  = r_value;

    assign s_end  = EW'(r_p) + EW'(run_q);
    assign s_next = EW'(r_start) + EW'(r_len);

    always_comb begin
        run_addr  = r_addr;
        run_we    = 1'b0;
        run_wdata = '0;
        bt_addr   = r_bt_addr;
        bt_we     = 1'b0;
        bt_wdata  = bt_q + LW'(1);
        case (r_state)
            S_CLEAR: begin
                run_addr = r_clr;
                run_we   = 1'b1;
                bt_addr  = BW'(r_clr);
                bt_we    = 32'(r_clr) < NUM_BLOCKS;
                bt_wdata = '0;
            end
            S_DISPATCH: run_addr = r_pg_addr;
            S_CHK:      run_addr = r_pg_addr - AW'(1);
            S_SCAN:     run_addr = r_addr - AW'(1);
            S_NXT:      run_addr = r_start_addr + AW'(r_len);
            S_WR: begin
                run_addr  = r_start_addr;
                run_we    = 1'b1;
                run_wdata = r_len;
            end
            S_CLR_NXT: begin
                run_addr = r_nxt_addr;
                run_we   = 1'b1;
            end
            S_BT_WR: bt_we = 1'b1;
            default: ;
        endcase
    end

    bpr_ram #(.WIDTH(LW), .DEPTH(DEPTH)) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (run_we),
        .i_addr  (run_addr),
        .i_wdata (run_wdata),
        .o_rdata (run_q)
    );

    bpr_ram #(.WIDTH(LW), .DEPTH(NUM_BLOCKS)) u_bt_ram (
        .i_clk   (i_clk),
        .i_we    (bt_we),
        .i_addr  (bt_addr),
        .i_wdata (bt_wdata),
        .o_rdata (bt_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (o_pop) begin
                        r_item  <= i_item;
                        r_state <= S_ADDR;
                    end
                end
                S_ADDR: begin
                    r_pg_addr <= AW'(32'(r_item.block) * 32'(PAGES_PER_BLOCK)
                                     + 32'(r_item.page));
                    r_pg      <= PW'(r_item.page);
                    r_bt_addr <= BW'(r_item.block);
                    r_state   <= S_DISPATCH;
                end
                S_DISPATCH: begin
                    unique case (r_item.kind)
                        K_INSERT: r_state <= S_CHK;
                        K_COUNT:  r_state <= S_CNT;
                        K_GET:    r_state <= S_GET;
                        default: begin
                            r_strobe <= 1'b1;
                            r_value  <= '0;
                            r_state  <= S_IDLE;
                        end
                    endcase
                end
                S_GET: begin
                    r_strobe <= 1'b1;
                    r_value  <= 8'(run_q);
                    r_state  <= S_IDLE;
                end
                S_CNT: begin
                    r_strobe <= 1'b1;
                    r_value  <= 8'(bt_q);
                    r_state  <= S_IDLE;
                end
                S_CHK: begin
                    if (run_q != '0) begin
                        r_strobe <= 1'b1;
                        r_value  <= '0;
                        r_state  <= S_IDLE;
                    end else if (r_pg == '0) begin
                        r_start      <= r_pg;
                        r_start_addr <= r_pg_addr;
                        r_len        <= LW'(1);
                        r_state      <= S_NXT;
                    end else begin
                        r_p     <= r_pg - PW'(1);
                        r_addr  <= r_pg_addr - AW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (run_q != '0) begin
                        if (s_end > EW'(r_pg)) begin
                            r_strobe <= 1'b1;
                            r_value  <= '0;
                            r_state  <= S_IDLE;
                        end else if (s_end == EW'(r_pg)) begin
                            r_start      <= r_p;
                            r_start_addr <= r_addr;
                            r_len        <= run_q + LW'(1);
                            r_state      <= S_NXT;
                        end else begin
                            r_start      <= r_pg;
                            r_start_addr <= r_pg_addr;
                            r_len        <= LW'(1);
                            r_state      <= S_NXT;
                        end
                    end else if (r_p == '0) begin
                        r_start      <= r_pg;
                        r_start_addr <= r_pg_addr;
                        r_len        <= LW'(1);
                        r_state      <= S_NXT;
                    end else begin
                        r_p    <= r_p - PW'(1);
                        r_addr <= r_addr - AW'(1);
                    end
                end
                S_NXT: begin
                    if (s_next < EW'(PAGES_PER_BLOCK)) begin
                        r_nxt_addr <= r_start_addr + AW'(r_len);
                        r_state    <= S_MRG;
                    end else begin
                        r_merge <= 1'b0;
                        r_state <= S_WR;
                    end
                end
                S_MRG: begin
                    r_len   <= r_len + run_q;
                    r_merge <= (run_q != '0);
                    r_state <= S_WR;
                end
                S_WR:      r_state <= r_merge ? S_CLR_NXT : S_BT_RD;
                S_CLR_NXT: r_state <= S_BT_RD;
                S_BT_RD:   r_state <= S_BT_WR;
                S_BT_WR: begin
                    r_strobe <= 1'b1;
                    r_value  <= '0;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_strobe_after_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> o_ready)
        else $error("result strobe during clearing pass");

    a_scan_below_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_p < r_pg))
        else $error("scan pointer not below inserted page");

    a_write_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR) |-> (r_len != '0))
        else $error("run written with zero length");

endmodule

@@ hdl/bad_page_run_table.sv @@
// ============================================================================
// Bad page run table
// Per-block record of bad flash pages kept as runs of consecutive pages.
// ============================================================================
// A command (i_cmd, i_block, i_page) transfers at a rising edge where start
// is high and busy is low. Commands: insert bad page, count bad pages in a
// block, get the run length stored at a page. Every command gives exactly one
// result on o_value, marked by o_strobe for one cycle; inserts return 0.
// Results come back in command order and cannot be held off by the receiver.
// A two-entry queue sits between the command side and the table engine, so
// up to two commands may be accepted while one is being carried out.
// An insert first checks the inserted page, then scans the pages below it one
// by one for the nearest run start, extends or starts a run, merges it with a
// run that begins right after it, and raises the block's bad page count. An
// insert of a page that is already bad ends at that check, or as soon as the
// scan reaches the run that holds it.
// After reset the engine sweeps both tables to zero, one entry per cycle,
// over all NUM_BLOCKS * PAGES_PER_BLOCK run table entries; busy stays high
// during the sweep.
// ============================================================================
module bad_page_run_table
    import bpr_pkg::*;
#(
    parameter int NUM_BLOCKS      = 256,
    parameter int PAGES_PER_BLOCK = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_block,
    input  logic [6:0] i_page,
    output logic       o_strobe,
    output logic [7:0] o_value
);

    t_q_status q_status;
    t_item     push_item;
    t_item     pop_item;
    logic      push;
    logic      pop;
    logic      ready;

    bpr_front #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK)
    ) u_front (
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .i_block    (i_block),
        .i_page     (i_page),
        .i_ready    (ready),
        .i_q_status (q_status),
        .o_push     (push),
        .o_item     (push_item)
    );

    bpr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_item   (pop_item),
        .o_status (q_status)
    );

    bpr_back #(
        .NUM_BLOCKS      (NUM_BLOCKS),
        .PAGES_PER_BLOCK (PAGES_PER_BLOCK)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_item     (pop_item),
        .o_pop      (pop),
        .o_ready    (ready),
        .o_strobe   (o_strobe),
        .o_value    (o_value)
    );

endmodule

@@ sim/bad_page_run_table_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bad page run table checker
// Watches command and result transfers, predicts each value from a local
// copy of the run table, and compares results in order.
// ----------------------------------------------------------------------------
module bad_page_run_table_checker
    import bpr_pkg::*;
#(
    parameter int NUM_BLOCKS      = 256,
    parameter int PAGES_PER_BLOCK = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_block,
    input  logic [6:0] i_page,
    input  logic       o_strobe,
    input  logic [7:0] o_value,
    output int         o_fail_count,
    output int         o_pending
);

    logic [15:0] run_len [NUM_BLOCKS * PAGES_PER_BLOCK];
    logic [15:0] bad_cnt [NUM_BLOCKS];
    logic [7:0]  value_q [$];

    function automatic void mark_page(int blk, int pg);
        int base;
        int first;
        int p;
        int stop;
        int nxt;
        bit found;
        base = blk * PAGES_PER_BLOCK;
        first = pg;
        found = 1'b0;
        if (run_len[base + pg] != 0) return;
        for (p = pg; p > 0; p--) begin
            if (run_len[base + p - 1] != 0) begin
                first = p - 1;
                found = 1'b1;
                break;
            end
        end
        if (found) begin
            stop = first + run_len[base + first];
            if (stop > pg) return;
            if (stop == pg) begin
                run_len[base + first] = run_len[base + first] + 16'd1;
            end else begin
                first = pg;
                run_len[base + pg] = 16'd1;
            end
        end else begin
            first = pg;
            run_len[base + pg] = 16'd1;
        end
        nxt = first + run_len[base + first];
        if (nxt < PAGES_PER_BLOCK && run_len[base + nxt] != 0) begin
            run_len[base + first] = run_len[base + first] + run_len[base + nxt];
            run_len[base + nxt] = '0;
        end
        bad_cnt[blk] = bad_cnt[blk] + 16'd1;
    endfunction

    function automatic logic [7:0] predict_value(t_cmd cmd, int blk, int pg);
        logic [15:0] v;
        bit blk_ok;
        bit pg_ok;
        v = '0;
        blk_ok = blk < NUM_BLOCKS;
        pg_ok = pg < PAGES_PER_BLOCK;
        case (cmd)
            CMD_INSERT: if (blk_ok && pg_ok) mark_page(blk, pg);
            CMD_COUNT: if (blk_ok) v = bad_cnt[blk];
            CMD_GET: if (blk_ok && pg_ok) v = run_len[blk * PAGES_PER_BLOCK + pg];
            default: v = '0;
        endcase
        return v[7:0];
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        foreach (run_len[i]) run_len[i] = '0;
        foreach (bad_cnt[i]) bad_cnt[i] = '0;
    end

    always @(posedge i_clk) begin
        logic [7:0] exp_v;
        if (i_rst_n) begin
            if (o_strobe) begin
                if (value_q.size() == 0) begin
                    $error("unexpected result: value actual %0d", o_value);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    exp_v = value_q.pop_front();
                    if (o_value !== exp_v) begin
                        $error("value mismatch: expected %0d actual %0d", exp_v, o_value);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (start && !busy)
                value_q.push_back(predict_value(t_cmd'(i_cmd), i_block, i_page));
            o_pending <= value_q.size();
        end
    end

endmodule

@@ sim/bad_page_run_table_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bad page run table testbench
// Drives directed and random insert, count and get commands with varying
// sender gaps; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module bad_page_run_table_tb;
    import bpr_pkg::*;

    localparam int LIMIT = 2000000;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic [1:0] i_cmd;
    logic [7:0] i_block;
    logic [6:0] i_page;
    logic       o_strobe;
    logic [7:0] o_value;
    int         fail_count;
    int         pending;
    int         cycle_count;
    int         gap_pct;

    bad_page_run_table uut (.*);

    bad_page_run_table_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cmd(i_cmd), .i_block(i_block), .i_page(i_page),
        .o_strobe(o_strobe), .o_value(o_value),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial i_clk = 0;
    always begin
        #6 i_clk = 1;
        #6 i_clk = 0;
    end

    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("bad_page_run_table verification failed");
            $finish;
        end
    end

    task automatic send_cmd(t_cmd cmd, logic [7:0] blk, logic [6:0] pg);
        if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
            while (gap_pct > 0 && $urandom_range(99) < gap_pct) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        i_block <= blk;
        i_page <= pg;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic random_phase(int n);
        logic [7:0] blk;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(99);
            blk = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(3));
            if (r < 55)
                send_cmd(CMD_INSERT, blk, 7'($urandom));
            else if (r < 70)
                send_cmd(CMD_COUNT, blk, 7'($urandom));
            else if (r < 95)
                send_cmd(CMD_GET, blk, 7'($urandom));
            else
                send_cmd(CMD_UNUSED, blk, 7'($urandom));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = CMD_INSERT;
        i_block = '0;
        i_page = '0;
        gap_pct = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_cmd(CMD_COUNT, 8'd255, 7'd0);
        send_cmd(CMD_INSERT, 8'd255, 7'd127);
        send_cmd(CMD_INSERT, 8'd255, 7'd0);
        send_cmd(CMD_INSERT, 8'd255, 7'd0);
        send_cmd(CMD_INSERT, 8'd0, 7'd5);
        send_cmd(CMD_INSERT, 8'd0, 7'd7);
        send_cmd(CMD_INSERT, 8'd0, 7'd6);
        send_cmd(CMD_INSERT, 8'd0, 7'd6);
        send_cmd(CMD_INSERT, 8'd0, 7'd4);
        send_cmd(CMD_GET, 8'd0, 7'd4);
        send_cmd(CMD_GET, 8'd0, 7'd5);
        send_cmd(CMD_COUNT, 8'd0, 7'd0);
        send_cmd(CMD_COUNT, 8'd255, 7'd127);
        send_cmd(CMD_GET, 8'd255, 7'd127);
        send_cmd(CMD_UNUSED, 8'd0, 7'd5);
        for (int p = 0; p < 128; p++) send_cmd(CMD_INSERT, 8'd1, 7'(127 - p));
        send_cmd(CMD_GET, 8'd1, 7'd0);
        send_cmd(CMD_COUNT, 8'd1, 7'd0);
        gap_pct = 20;
        random_phase(150);
        gap_pct = 82;
        random_phase(150);
        gap_pct = 0;
        random_phase(150);
        start <= 1'b0;
        while (pending > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("bad_page_run_table verification clean");
        else
            $display("bad_page_run_table verification failed");
        $finish;
    end

endmodule
